[src/cdq_pkg.sv]
// ============================================================================
// cdq_pkg
// Shared types and constants for the circular deque unit.
// ============================================================================
`default_nettype none

package cdq_pkg;

   localparam int unsigned WORD_W = 32;
   localparam int unsigned MODE_W = 3;
   localparam int unsigned OCC_W  = 8;

   localparam logic [MODE_W-1:0] MODE_PUSH_FRONT = 3'd0;
   localparam logic [MODE_W-1:0] MODE_PUSH_BACK  = 3'd1;
   localparam logic [MODE_W-1:0] MODE_POP_FRONT  = 3'd2;
   localparam logic [MODE_W-1:0] MODE_POP_BACK   = 3'd3;
   localparam logic [MODE_W-1:0] MODE_NONE       = 3'd4;

   // reported for front and back when nothing is held
   localparam logic signed [WORD_W-1:0] EMPTY_WORD = -32'sd1;

   // Broadcast to every cell. Row A keeps the front at cell 0, row B keeps
   // the back at cell 0; each row grows at the far end by a load at the
   // cell whose index equals the current count.
   typedef struct packed {
      logic a_shr;
      logic a_shl;
      logic a_load;
      logic b_shr;
      logic b_shl;
      logic b_load;
   } cell_ctl_type;

endpackage

`default_nettype wire

[src/cdq_req_if.sv]
// ============================================================================
// cdq_req_if
// Request channel: one deque operation per transaction.
// ============================================================================
`default_nettype none

interface cdq_req_if;
   logic                                  valid;
   logic                                  ready;
   logic [cdq_pkg::MODE_W-1:0]            mode;
   logic signed [cdq_pkg::WORD_W-1:0]     value;

   modport source (output valid, output mode, output value, input ready);
   modport sink   (input valid, input mode, input value, output ready);
endinterface

`default_nettype wire

[src/cdq_rsp_if.sv]
// ============================================================================
// cdq_rsp_if
// Response channel: deque status after each operation.
// ============================================================================
`default_nettype none

interface cdq_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [cdq_pkg::WORD_W-1:0]     front_value;
   logic signed [cdq_pkg::WORD_W-1:0]     back_value;
   logic [cdq_pkg::OCC_W-1:0]             occupancy;
   logic                                  is_empty;
   logic                                  is_full;
   logic                                  dropped;

   modport source (output valid, output front_value, output back_value,
                   output occupancy, output is_empty, output is_full,
                   output dropped, input ready);
   modport sink   (input valid, input front_value, input back_value,
                   input occupancy, input is_empty, input is_full,
                   input dropped, output ready);
endinterface

`default_nettype wire

[src/circular_deque_unit.sv]
// ============================================================================
// circular_deque_unit
// Double-ended queue of DEPTH signed words built as a row of shifting cells.
// ============================================================================
// Usage:
//   req_if carries one operation per transaction: mode (push front, push
//   back, pop front, pop back, none) and the word to push. rsp_if returns one
//   transaction per request: front and back words (-1 when empty), occupancy,
//   empty and full flags, and a dropped flag for a push on full or a pop on
//   empty, which leaves the contents untouched.
//   A request passes the status stage, then the response register. One
//   request is taken every cycle while the receiver does not stall: the
//   cell row applies each operation as it is taken, and the front and
//   back words sit at cell 0 of their rows, so answers come from fixed places.
//   The response register and the status stage between them hold one
//   result each; while the receiver stalls the status stage fills and
//   req_if.ready drops until the response is taken.
//   Synchronous reset empties the deque and clears both stages; the cell
//   words are not cleared and are only ever read after being written.
// ============================================================================
`default_nettype none

module circular_deque_unit #(
   parameter int unsigned DEPTH = 128
) (
   input  wire logic    clock,
   input  wire logic    reset,
   cdq_req_if.sink      req_if,
   cdq_rsp_if.source    rsp_if
);

   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               upd_valid_ff;
   logic               upd_valid_in;
   logic               upd_drop_ff;
   logic               upd_drop_in;
   logic               rsp_valid_ff;
   logic               rsp_valid_in;

   logic signed [cdq_pkg::WORD_W-1:0] rsp_front_ff;
   logic signed [cdq_pkg::WORD_W-1:0] rsp_back_ff;
   logic [cdq_pkg::OCC_W-1:0]         rsp_occ_ff;
   logic                              rsp_empty_ff;
   logic                              rsp_full_ff;
   logic                              rsp_drop_ff;

   logic signed [cdq_pkg::WORD_W-1:0] a_word [DEPTH];
   logic signed [cdq_pkg::WORD_W-1:0] b_word [DEPTH];

   cdq_pkg::cell_ctl_type ctl;

   logic out_free;
   logic req_fire;
   logic is_push;
   logic is_pop;
   logic is_empty;
   logic is_full;
   logic do_push;
   logic do_pop;
   logic is_front;

   assign out_free      = !rsp_valid_ff || rsp_if.ready;
   assign req_if.ready  = !upd_valid_ff || out_free;
   assign req_fire      = req_if.valid && req_if.ready;

   assign is_push  = (req_if.mode == cdq_pkg::MODE_PUSH_FRONT) ||
                     (req_if.mode == cdq_pkg::MODE_PUSH_BACK);
   assign is_pop   = (req_if.mode == cdq_pkg::MODE_POP_FRONT) ||
                     (req_if.mode == cdq_pkg::MODE_POP_BACK);
   assign is_front = (req_if.mode == cdq_pkg::MODE_PUSH_FRONT) ||
                     (req_if.mode == cdq_pkg::MODE_POP_FRONT);
   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   assign do_push = req_fire && is_push && !is_full;
   assign do_pop  = req_fire && is_pop && !is_empty;

   // A push at one end shifts that end's row and loads the other row at
   // its tail; a pop shifts only the row whose head is leaving.
   always_comb begin
      ctl.a_shr  = do_push && is_front;
      ctl.b_load = do_push && is_front;
      ctl.b_shr  = do_push && !is_front;
      ctl.a_load = do_push && !is_front;
      ctl.a_shl  = do_pop && is_front;
      ctl.b_shl  = do_pop && !is_front;
   end

   always_comb begin
      priority if (do_push) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop) begin
         count_in = count_ff - CNT_W'(1);
      end else begin
         count_in = count_ff;
      end
   end

   assign upd_drop_in  = (is_push && is_full) || (is_pop && is_empty);
   assign upd_valid_in = req_fire || (upd_valid_ff && !out_free);
   assign rsp_valid_in = upd_valid_ff || (rsp_valid_ff && !rsp_if.ready);

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [cdq_pkg::WORD_W-1:0] a_left;
      logic signed [cdq_pkg::WORD_W-1:0] a_right;
      logic signed [cdq_pkg::WORD_W-1:0] b_left;
      logic signed [cdq_pkg::WORD_W-1:0] b_right;

      if (i == 0) begin : g_head
         assign a_left = req_if.value;
         assign b_left = req_if.value;
      end else begin : g_mid
         assign a_left = a_word[i-1];
         assign b_left = b_word[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign a_right = '0;
         assign b_right = '0;
      end else begin : g_inner
         assign a_right = a_word[i+1];
         assign b_right = b_word[i+1];
      end

      cdq_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .at_tail (count_ff == CNT_W'(i)),
         .value   (req_if.value),
         .a_left  (a_left),
         .a_right (a_right),
         .b_left  (b_left),
         .b_right (b_right),
         .a_ff    (a_word[i]),
         .b_ff    (b_word[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         upd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         upd_valid_ff <= upd_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         upd_drop_ff <= upd_drop_in;
      end
   end

   // the cells and count already reflect the transaction held in the
   // status stage, so the response is taken straight from them
   always_ff @(posedge clock) begin
      if (upd_valid_ff && out_free) begin
         rsp_front_ff <= is_empty ? cdq_pkg::EMPTY_WORD : a_word[0];
         rsp_back_ff  <= is_empty ? cdq_pkg::EMPTY_WORD : b_word[0];
         rsp_occ_ff   <= cdq_pkg::OCC_W'(count_ff);
         rsp_empty_ff <= is_empty;
         rsp_full_ff  <= is_full;
         rsp_drop_ff  <= upd_drop_ff;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.front_value = rsp_front_ff;
   assign rsp_if.back_value  = rsp_back_ff;
   assign rsp_if.occupancy   = rsp_occ_ff;
   assign rsp_if.is_empty    = rsp_empty_ff;
   assign rsp_if.is_full     = rsp_full_ff;
   assign rsp_if.dropped     = rsp_drop_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("deque count beyond depth");

   a_push_front_head: assert property (@(posedge clock) disable iff (reset)
      (do_push && is_front) |=> (a_word[0] == $past(req_if.value)))
      else $error("front row head not loaded on push front");

   a_push_back_head: assert property (@(posedge clock) disable iff (reset)
      (do_push && !is_front) |=> (b_word[0] == $past(req_if.value)))
      else $error("back row head not loaded on push back");

   a_stage_hold: assert property (@(posedge clock) disable iff (reset)
      (upd_valid_ff && !out_free) |=> upd_valid_ff)
      else $error("status transaction lost while response stalled");

endmodule

`default_nettype wire

[src/cdq_cell.sv]
// ============================================================================
// cdq_cell
// One position of the deque: a word of the front-ordered row and a word of
// the back-ordered row, each shifting to or from its neighbours.
// ============================================================================
`default_nettype none

module cdq_cell (
   input  wire logic                                clock,
   input  wire cdq_pkg::cell_ctl_type               ctl,
   input  wire logic                                at_tail,
   input  wire logic signed [cdq_pkg::WORD_W-1:0]   value,
   input  wire logic signed [cdq_pkg::WORD_W-1:0]   a_left,
   input  wire logic signed [cdq_pkg::WORD_W-1:0]   a_right,
   input  wire logic signed [cdq_pkg::WORD_W-1:0]   b_left,
   input  wire logic signed [cdq_pkg::WORD_W-1:0]   b_right,
   output      logic signed [cdq_pkg::WORD_W-1:0]   a_ff,
   output      logic signed [cdq_pkg::WORD_W-1:0]   b_ff
);

   logic signed [cdq_pkg::WORD_W-1:0] a_in;
   logic signed [cdq_pkg::WORD_W-1:0] b_in;

   // at most one of the controls per row is set in any cycle
   always_comb begin
      priority if (ctl.a_shr) begin
         a_in = a_left;
      end else if (ctl.a_shl) begin
         a_in = a_right;
      end else if (ctl.a_load && at_tail) begin
         a_in = value;
      end else begin
         a_in = a_ff;
      end
   end

   always_comb begin
      priority if (ctl.b_shr) begin
         b_in = b_left;
      end else if (ctl.b_shl) begin
         b_in = b_right;
      end else if (ctl.b_load && at_tail) begin
         b_in = value;
      end else begin
         b_in = b_ff;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

`default_nettype wire
